// ----- rtl/ffha_pkg.sv -----
package ffha_pkg;

  localparam int unsigned WORDS_W   = 21;
  localparam int unsigned MUL_SHIFT = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [19:0] req_bytes;
    logic [15:0] address;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] granted_address;
    logic [8:0]  free_entries;
    logic [8:0]  used_entries;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_INC, CMD_F_RD_IDX, CMD_A_TAKE, CMD_F_SHD_RD, CMD_F_SHD_WR,
    CMD_F_DEC, CMD_U_SHD_RD, CMD_U_SHD_WR, CMD_U_DEC, CMD_UI_INIT, CMD_U_RD_PREV,
    CMD_UI_SHIFT, CMD_UI_PUT, CMD_U_RD_IDX, CMD_F_LATCH_U, CMD_FI_INIT, CMD_FI_PREV,
    CMD_FI_STOP, CMD_MERGE_BOTH, CMD_MERGE_PREV, CMD_MERGE_NEXT, CMD_SHU_INIT,
    CMD_F_RD_PREV, CMD_SHU_WR, CMD_F_PUT, CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero;
    logic idx_eq_fc;
    logic idx_eq_uc;
    logic idx_eq_p;
    logic idx_zero;
    logic idx1_ge_fc;
    logic idx1_ge_uc;
    logic uc_full;
    logic fc_full;
    logic fit;
    logic exact;
    logic u_hit;
    logic f_gt;
    logic u_lt;
    logic mp;
    logic mn;
  } flags_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_A_RD, S_A_CMP, S_FSD_RD, S_FSD_WR, S_UI_INIT, S_UI_RD,
    S_UI_CMP, S_U_RD, S_U_CMP, S_USD_RD, S_USD_WR, S_FI_INIT, S_FI_RD, S_FI_CMP,
    S_DECIDE, S_SHU_RD, S_SHU_WR, S_FINISH
  } state_e;

endpackage

// ----- rtl/ffha_dp.sv -----
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned HEAP_WORDS  = 65536,
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_BYTES  = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  in_t    req_i,
  input  cmd_t   cmd_i,
  output flags_t flags_o,
  output out_t   res_o
);

  localparam int unsigned AW    = $clog2(HEAP_WORDS);
  localparam int unsigned SW    = $clog2(HEAP_WORDS + 1);
  localparam int unsigned IW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW    = (SW > WORDS_W) ? SW : WORDS_W;
  localparam int unsigned HW    = (AW > 16) ? AW : 16;
  localparam int unsigned ENW   = AW + SW;
  localparam int unsigned PW    = WORDS_W + MUL_SHIFT + 1;
  localparam int unsigned RECIP = (2 ** MUL_SHIFT + WORD_BYTES - 1) / WORD_BYTES;

  logic [ENW-1:0] f_mem [TABLE_DEPTH];
  logic [ENW-1:0] u_mem [TABLE_DEPTH];

  op_e               op_q;
  logic [WORDS_W-1:0] words_q;
  logic [15:0]       addr_q;
  logic [CW-1:0]     idx_q, p_q, fc_q, uc_q;
  logic [AW-1:0]     c_start_q, prev_start_q, next_start_q, granted_q;
  logic [SW-1:0]     c_size_q, prev_size_q, next_size_q;
  logic              f0_init_q, f_init_rd_q;
  logic [ENW-1:0]    f_raw_q, u_rd_q;
  logic [ENW-1:0]    f_rd;
  out_t              res_q;

  logic              f_we, f_re, u_we, u_re;
  logic [IW-1:0]     f_waddr, f_raddr, u_waddr, u_raddr;
  logic [ENW-1:0]    f_wdata, u_wdata;

  logic [CW-1:0]     idx_p1, idx_m1;
  logic [AW-1:0]     f_start, u_start;
  logic [SW-1:0]     f_size, w_s;
  logic [WORDS_W-1:0] bytes_ext;
  logic [PW-1:0]     prod;

  assign idx_p1  = idx_q + CW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign f_rd    = f_init_rd_q ? {AW'(0), SW'(HEAP_WORDS)} : f_raw_q;
  assign f_start = f_rd[ENW-1:SW];
  assign f_size  = f_rd[SW-1:0];
  assign u_start = u_rd_q[ENW-1:SW];
  assign w_s     = SW'(words_q);

  // ceiling division by the word size through a scaled reciprocal
  assign bytes_ext = WORDS_W'(req_i.req_bytes) + WORDS_W'(WORD_BYTES - 1);
  assign prod      = PW'(bytes_ext) * PW'(RECIP);

  always_comb begin
    f_we = 1'b0; f_re = 1'b0; u_we = 1'b0; u_re = 1'b0;
    f_waddr = idx_q[IW-1:0]; f_raddr = idx_q[IW-1:0];
    u_waddr = idx_q[IW-1:0]; u_raddr = idx_q[IW-1:0];
    f_wdata = f_rd; u_wdata = u_rd_q;
    unique case (cmd_i.op)
      CMD_F_RD_IDX: f_re = 1'b1;
      CMD_A_TAKE: begin
        f_we    = (f_size != w_s);
        f_wdata = {AW'(SW'(f_start) + w_s), f_size - w_s};
      end
      CMD_F_SHD_RD: begin
        f_re = 1'b1; f_raddr = idx_p1[IW-1:0];
      end
      CMD_F_SHD_WR: f_we = 1'b1;
      CMD_U_SHD_RD: begin
        u_re = 1'b1; u_raddr = idx_p1[IW-1:0];
      end
      CMD_U_SHD_WR: u_we = 1'b1;
      CMD_U_RD_PREV: begin
        u_re = 1'b1; u_raddr = idx_m1[IW-1:0];
      end
      CMD_UI_SHIFT: u_we = 1'b1;
      CMD_UI_PUT: begin
        u_we = 1'b1; u_wdata = {c_start_q, w_s};
      end
      CMD_U_RD_IDX: u_re = 1'b1;
      CMD_MERGE_BOTH: begin
        f_we    = 1'b1; f_waddr = idx_m1[IW-1:0];
        f_wdata = {prev_start_q, prev_size_q + c_size_q + next_size_q};
      end
      CMD_MERGE_PREV: begin
        f_we    = 1'b1; f_waddr = idx_m1[IW-1:0];
        f_wdata = {prev_start_q, prev_size_q + c_size_q};
      end
      CMD_MERGE_NEXT: begin
        f_we = 1'b1; f_wdata = {c_start_q, c_size_q + next_size_q};
      end
      CMD_F_RD_PREV: begin
        f_re = 1'b1; f_raddr = idx_m1[IW-1:0];
      end
      CMD_SHU_WR: f_we = 1'b1;
      CMD_F_PUT: begin
        f_we = 1'b1; f_wdata = {c_start_q, c_size_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (f_we) f_mem[f_waddr] <= f_wdata;
    if (f_re) f_raw_q <= f_mem[f_raddr];
    if (u_we) u_mem[u_waddr] <= u_wdata;
    if (u_re) u_rd_q <= u_mem[u_raddr];
  end

  // entry 0 of the free table reads as the whole heap until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_init_q   <= 1'b1;
      f_init_rd_q <= 1'b0;
    end else begin
      if (f_we && f_waddr == '0) f0_init_q <= 1'b0;
      if (f_re) f_init_rd_q <= f0_init_q && (f_raddr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      p_q   <= '0;
      fc_q  <= CW'(1);
      uc_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        CMD_LOAD, CMD_FI_INIT:           idx_q <= '0;
        CMD_INC, CMD_F_SHD_WR,
        CMD_U_SHD_WR, CMD_FI_PREV:       idx_q <= idx_p1;
        CMD_UI_SHIFT, CMD_SHU_WR:        idx_q <= idx_m1;
        CMD_F_DEC:                       fc_q  <= fc_q - CW'(1);
        CMD_U_DEC:                       uc_q  <= uc_q - CW'(1);
        CMD_UI_INIT:                     idx_q <= uc_q;
        CMD_UI_PUT:                      uc_q  <= uc_q + CW'(1);
        CMD_FI_STOP:                     p_q   <= idx_q;
        CMD_SHU_INIT:                    idx_q <= fc_q;
        CMD_F_PUT:                       fc_q  <= fc_q + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        op_q      <= req_i.op;
        words_q   <= prod[MUL_SHIFT +: WORDS_W];
        addr_q    <= req_i.address;
        granted_q <= '0;
      end
      CMD_A_TAKE: begin
        c_start_q <= f_start;
        c_size_q  <= f_size;
      end
      CMD_UI_PUT: granted_q <= c_start_q;
      CMD_F_LATCH_U: begin
        c_start_q <= u_start;
        c_size_q  <= u_rd_q[SW-1:0];
      end
      CMD_FI_PREV: begin
        prev_start_q <= f_start;
        prev_size_q  <= f_size;
      end
      CMD_FI_STOP: begin
        next_start_q <= f_start;
        next_size_q  <= f_size;
      end
      CMD_FINISH: begin
        res_q.status          <= cmd_i.status;
        res_q.granted_address <= 16'(granted_q);
        res_q.free_entries    <= 9'(fc_q);
        res_q.used_entries    <= 9'(uc_q);
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_comb begin
    flags_o.is_free    = (op_q == OP_FREE);
    flags_o.zero       = (words_q == '0);
    flags_o.idx_eq_fc  = (idx_q == fc_q);
    flags_o.idx_eq_uc  = (idx_q == uc_q);
    flags_o.idx_eq_p   = (idx_q == p_q);
    flags_o.idx_zero   = (idx_q == '0);
    flags_o.idx1_ge_fc = (idx_p1 >= fc_q);
    flags_o.idx1_ge_uc = (idx_p1 >= uc_q);
    flags_o.uc_full    = (uc_q == CW'(TABLE_DEPTH));
    flags_o.fc_full    = (fc_q == CW'(TABLE_DEPTH));
    flags_o.fit        = (EW'(f_size) >= EW'(words_q));
    flags_o.exact      = (EW'(f_size) == EW'(words_q));
    flags_o.u_hit      = (HW'(u_start) == HW'(addr_q));
    flags_o.f_gt       = (f_start > c_start_q);
    flags_o.u_lt       = (c_start_q < u_start);
    flags_o.mp         = (idx_q != '0) &&
                         (SW'(prev_start_q) + prev_size_q == SW'(c_start_q));
    flags_o.mn         = (idx_q != fc_q) &&
                         (SW'(c_start_q) + c_size_q == SW'(next_start_q));
  end

endmodule

// ----- rtl/ffha_ctrl.sv -----
module ffha_ctrl import ffha_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  input  flags_t flags_i,
  output cmd_t   cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op     = CMD_NOP;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          st_d     = ST_OK;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags_i.is_free) state_d = S_U_RD;
        else if (flags_i.zero) begin
          st_d = ST_ZERO; state_d = S_FINISH;
        end else state_d = S_A_RD;
      end
      S_A_RD: begin
        if (flags_i.idx_eq_fc) begin
          st_d = ST_NOFIT; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_F_RD_IDX; state_d = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (!flags_i.fit) begin
          cmd_o.op = CMD_INC; state_d = S_A_RD;
        end else if (flags_i.uc_full) begin
          st_d = ST_FULL; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_A_TAKE;
          state_d  = flags_i.exact ? S_FSD_RD : S_UI_INIT;
        end
      end
      S_FSD_RD: begin
        if (flags_i.idx1_ge_fc) begin
          cmd_o.op = CMD_F_DEC;
          state_d  = flags_i.is_free ? S_FINISH : S_UI_INIT;
        end else begin
          cmd_o.op = CMD_F_SHD_RD; state_d = S_FSD_WR;
        end
      end
      S_FSD_WR: begin
        cmd_o.op = CMD_F_SHD_WR; state_d = S_FSD_RD;
      end
      S_UI_INIT: begin
        cmd_o.op = CMD_UI_INIT; state_d = S_UI_RD;
      end
      S_UI_RD: begin
        if (flags_i.idx_zero) begin
          cmd_o.op = CMD_UI_PUT; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_U_RD_PREV; state_d = S_UI_CMP;
        end
      end
      S_UI_CMP: begin
        if (flags_i.u_lt) begin
          cmd_o.op = CMD_UI_SHIFT; state_d = S_UI_RD;
        end else begin
          cmd_o.op = CMD_UI_PUT; state_d = S_FINISH;
        end
      end
      S_U_RD: begin
        if (flags_i.idx_eq_uc) begin
          st_d = ST_UNKNOWN; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_U_RD_IDX; state_d = S_U_CMP;
        end
      end
      S_U_CMP: begin
        if (!flags_i.u_hit) begin
          cmd_o.op = CMD_INC; state_d = S_U_RD;
        end else if (flags_i.fc_full) begin
          st_d = ST_FULL; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_F_LATCH_U; state_d = S_USD_RD;
        end
      end
      S_USD_RD: begin
        if (flags_i.idx1_ge_uc) begin
          cmd_o.op = CMD_U_DEC; state_d = S_FI_INIT;
        end else begin
          cmd_o.op = CMD_U_SHD_RD; state_d = S_USD_WR;
        end
      end
      S_USD_WR: begin
        cmd_o.op = CMD_U_SHD_WR; state_d = S_USD_RD;
      end
      S_FI_INIT: begin
        cmd_o.op = CMD_FI_INIT; state_d = S_FI_RD;
      end
      S_FI_RD: begin
        if (flags_i.idx_eq_fc) begin
          cmd_o.op = CMD_FI_STOP; state_d = S_DECIDE;
        end else begin
          cmd_o.op = CMD_F_RD_IDX; state_d = S_FI_CMP;
        end
      end
      S_FI_CMP: begin
        if (flags_i.f_gt) begin
          cmd_o.op = CMD_FI_STOP; state_d = S_DECIDE;
        end else begin
          cmd_o.op = CMD_FI_PREV; state_d = S_FI_RD;
        end
      end
      S_DECIDE: begin
        priority if (flags_i.mp && flags_i.mn) begin
          // neighbour below absorbs both, then the upper one is removed
          cmd_o.op = CMD_MERGE_BOTH; state_d = S_FSD_RD;
        end else if (flags_i.mp) begin
          cmd_o.op = CMD_MERGE_PREV; state_d = S_FINISH;
        end else if (flags_i.mn) begin
          cmd_o.op = CMD_MERGE_NEXT; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_SHU_INIT; state_d = S_SHU_RD;
        end
      end
      S_SHU_RD: begin
        if (flags_i.idx_eq_p) begin
          cmd_o.op = CMD_F_PUT; state_d = S_FINISH;
        end else begin
          cmd_o.op = CMD_F_RD_PREV; state_d = S_SHU_WR;
        end
      end
      S_SHU_WR: begin
        cmd_o.op = CMD_SHU_WR; state_d = S_SHU_RD;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = CMD_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator over a word-addressed heap, keeping address-sorted free and
// allocated chunk tables in two single-port-per-direction memories of TABLE_DEPTH entries.
// One request is handled at a time; every table step is a registered memory read followed
// by a compare or write, so a request's run time grows with the entries scanned or shifted:
// an allocate scans the free table, shifts it on an exact fit and inserts into the used
// table; a free scans and shifts the used table, then scans the free table and merges or
// shifts it. The result waits in an output register, and the next request is taken as soon
// as the sequencer is idle.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_WORDS  = 65536,
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_BYTES  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t   cmd;
  flags_t flags;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  ffha_dp #(
    .HEAP_WORDS  (HEAP_WORDS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_BYTES  (WORD_BYTES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (in_data_i),
    .cmd_i   (cmd),
    .flags_o (flags),
    .res_o   (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a transaction is in progress");

  a_no_grant_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.granted_address == '0)
    else $error("granted address set on a failed transaction");

endmodule
